@@ src/oft_pkg.sv @@
// ----------------------------------------------------------------------------
// oft_pkg: shared types and constants for the open file table
// Request and response beat layouts, request kinds, status codes, table
// sizing, and the structs that pass between the table and its control.
// ----------------------------------------------------------------------------
`default_nettype none

package oft_pkg;

  // Table sizing.
  localparam int SLOTS    = 5;
  localparam int KEY_BITS = 16;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths of the request and response beats.
  localparam int KIND_W   = 2;
  localparam int FKEY_W   = 16;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SIDX_W   = 3;

  // Request kinds. The unused code is served as a lookup.
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALREADY_OPEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL         = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_OPEN     = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [FKEY_W-1:0] file_key;
    logic [MODE_W-1:0] access_mode;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIDX_W-1:0]   slot_index;
  } out_item_t;

  // Search results from the table for the current key.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_ok;
    logic [SLOT_W-1:0] free_idx;
  } search_t;

  // Update command into the table.
  typedef struct packed {
    logic                set;
    logic                clr;
    logic [SLOT_W-1:0]   idx;
    logic [KEY_BITS-1:0] key;
    logic [MODE_W-1:0]   mode;
  } update_t;

endpackage

`default_nettype wire

@@ src/open_file_table.sv @@
// Path: a request beat accepted by in_ready passes through the input register
// and then the response register before its response beat is valid.
// Throughput: one request per cycle unless out_ready stalls the response; set
// by the parallel key compare and free-slot encoder feeding the table update.
// Reset: synchronous, active low; every slot is freed and both pipeline
// stages are emptied.
// ----------------------------------------------------------------------------
// open_file_table: fully associative table of open files
// Serves lookup, open and close requests against a small slot table, one
// response beat per request beat, with valid/ready on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module open_file_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire oft_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output oft_pkg::out_item_t      out_item
);

  oft_pkg::in_item_t  req_r;
  logic               req_valid_r;
  oft_pkg::out_item_t rsp_r;
  oft_pkg::out_item_t rsp_nxt;
  logic               rsp_valid_r;
  logic               advance;
  oft_pkg::search_t   srch;
  oft_pkg::update_t   upd;
  logic [oft_pkg::KEY_BITS-1:0] req_key;

  // The request stage moves on whenever the response register is free or
  // being drained this cycle.
  assign advance  = !rsp_valid_r || out_ready;
  assign in_ready = !req_valid_r || advance;
  assign req_key  = oft_pkg::KEY_BITS'(req_r.file_key);

  oft_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (req_key),
    .srch  (srch),
    .upd   (upd)
  );

  // Decide the response and the table update for the registered request.
  always_comb begin
    rsp_nxt  = '0;
    upd      = '0;
    upd.key  = req_key;
    upd.mode = req_r.access_mode;
    unique case (req_r.kind)
      oft_pkg::KIND_OPEN: begin
        if (srch.hit) begin
          rsp_nxt.status = oft_pkg::ST_ALREADY_OPEN;
        end else if (!srch.free_ok) begin
          rsp_nxt.status = oft_pkg::ST_FULL;
        end else begin
          rsp_nxt.status     = oft_pkg::ST_OK;
          rsp_nxt.slot_index = oft_pkg::SIDX_W'(srch.free_idx);
          upd.set            = req_valid_r && advance;
          upd.idx            = srch.free_idx;
        end
      end
      oft_pkg::KIND_CLOSE: begin
        if (srch.hit) begin
          rsp_nxt.status     = oft_pkg::ST_OK;
          rsp_nxt.slot_index = oft_pkg::SIDX_W'(srch.hit_idx);
          upd.clr            = req_valid_r && advance;
          upd.idx            = srch.hit_idx;
        end else begin
          rsp_nxt.status = oft_pkg::ST_NOT_OPEN;
        end
      end
      default: begin
        if (srch.hit) begin
          rsp_nxt.status     = oft_pkg::ST_OK;
          rsp_nxt.slot_index = oft_pkg::SIDX_W'(srch.hit_idx);
        end else begin
          rsp_nxt.status = oft_pkg::ST_NOT_OPEN;
        end
      end
    endcase
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_item;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else if (advance) begin
      rsp_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid_r) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = rsp_valid_r;
  assign out_item  = rsp_r;

endmodule

`default_nettype wire

@@ src/oft_table.sv @@
// ----------------------------------------------------------------------------
// oft_table: slot storage with parallel key search
// Holds the valid bit, key and mode of every slot, compares the key against
// all slots at once, and finds the lowest matching and lowest free slots.
// ----------------------------------------------------------------------------
`default_nettype none

module oft_table (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [oft_pkg::KEY_BITS-1:0] key,
  output oft_pkg::search_t                  srch,
  input  wire oft_pkg::update_t             upd
);

  logic [oft_pkg::SLOTS-1:0]    valid_r;
  logic [oft_pkg::KEY_BITS-1:0] key_r  [oft_pkg::SLOTS];
  logic [oft_pkg::MODE_W-1:0]   mode_r [oft_pkg::SLOTS];
  logic [oft_pkg::SLOTS-1:0]    match;

  // Compare the key against every occupied slot.
  always_comb begin
    for (int i = 0; i < oft_pkg::SLOTS; i++) begin
      match[i] = valid_r[i] && (key_r[i] == key);
    end
  end

  // Lowest matching slot and lowest free slot; scanning downward lets the
  // lowest index win.
  always_comb begin
    srch = '0;
    for (int i = oft_pkg::SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        srch.hit     = 1'b1;
        srch.hit_idx = oft_pkg::SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        srch.free_ok  = 1'b1;
        srch.free_idx = oft_pkg::SLOT_W'(i);
      end
    end
  end

  // Valid bits clear on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (upd.set) begin
      valid_r[upd.idx] <= 1'b1;
    end else if (upd.clr) begin
      valid_r[upd.idx] <= 1'b0;
    end
  end

  // Key and mode are only read while the slot is valid.
  always_ff @(posedge clk) begin
    if (upd.set) begin
      key_r[upd.idx]  <= upd.key;
      mode_r[upd.idx] <= upd.mode;
    end
  end

endmodule

`default_nettype wire
